>>> rtl/core/pixel_point_op_ellipse_roi_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the ellipse ROI point-op block
// Shared property wrappers used by the RTL checks.
// -----------------------------------------------------------------------------
`ifndef PIXEL_POINT_OP_ELLIPSE_ROI_DEFINES_SVH
`define PIXEL_POINT_OP_ELLIPSE_ROI_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define PPOE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppoe check failed");

// Next-cycle implication, checked through reset as well.
`define PPOE_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ppoe check failed");

`endif

>>> rtl/core/ppoe_pkg.sv
// -----------------------------------------------------------------------------
// ppoe_pkg
// Shared types and constants for the ellipse ROI point-op pipeline.
// -----------------------------------------------------------------------------
package ppoe_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CFG_IDX_W      = 3;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE    = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_BRIGHTNESS = 3'd2,
    REG_MASK_EN    = 3'd3,
    REG_CENTER_X   = 3'd4,
    REG_CENTER_Y   = 3'd5,
    REG_RADIUS_X   = 3'd6,
    REG_RADIUS_Y   = 3'd7
  } cfg_reg_e;

  localparam logic [7:0] THRESHOLD_RST = 8'd127;

  typedef enum logic {
    OP_THRESHOLD  = 1'b0,
    OP_BRIGHTNESS = 1'b1
  } op_mode_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // per-stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_ld_t;

endpackage

>>> rtl/core/ppoe_pix_in_if.sv
// -----------------------------------------------------------------------------
// ppoe_pix_in_if
// Pixel input channel: position plus RGB, valid/ready handshake.
// -----------------------------------------------------------------------------
interface ppoe_pix_in_if #(
  parameter int COORD_BITS = ppoe_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;

  modport source (output valid, pos_x, pos_y, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, pos_x, pos_y, in_red, in_green, in_blue, output ready);
endinterface

>>> rtl/core/ppoe_pix_out_if.sv
// -----------------------------------------------------------------------------
// ppoe_pix_out_if
// Processed pixel channel: RGB plus changed flag, valid/ready handshake.
// -----------------------------------------------------------------------------
interface ppoe_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       was_changed;

  modport source (output valid, out_red, out_green, out_blue, was_changed, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, was_changed, output ready);
endinterface

>>> rtl/core/ppoe_pixel_op.sv
// -----------------------------------------------------------------------------
// ppoe_pixel_op
// Threshold to black/white or saturating brightness offset on one pixel.
// -----------------------------------------------------------------------------
module ppoe_pixel_op (
  input  logic              op_mode,
  input  logic [7:0]        threshold_level,
  input  logic signed [8:0] brightness_offset,
  input  ppoe_pkg::rgb_t    pix,
  output ppoe_pkg::rgb_t    result
);
  import ppoe_pkg::*;

  localparam logic [7:0] PIX_MAX = 8'd255;

  function automatic logic [7:0] add_clamp(logic [7:0] chan, logic signed [8:0] off);
    logic signed [9:0] sum;
    sum = $signed({2'b00, chan}) + $signed({off[8], off});
    if (sum < 0) begin
      add_clamp = '0;
    end else if (sum > $signed({2'b00, PIX_MAX})) begin
      add_clamp = PIX_MAX;
    end else begin
      add_clamp = sum[7:0];
    end
  endfunction

  logic [7:0] bw;

  // packed R:G:B compared against t:t:t
  assign bw = ({pix.red, pix.green, pix.blue} <
               {threshold_level, threshold_level, threshold_level}) ? 8'd0 : PIX_MAX;

  always_comb begin
    case (op_mode_e'(op_mode))
      OP_THRESHOLD: begin
        result = '{red: bw, green: bw, blue: bw};
      end
      OP_BRIGHTNESS: begin
        result.red   = add_clamp(pix.red,   brightness_offset);
        result.green = add_clamp(pix.green, brightness_offset);
        result.blue  = add_clamp(pix.blue,  brightness_offset);
      end
      default: begin
        result = pix;
      end
    endcase
  end

endmodule

>>> rtl/core/ppoe_ellipse.sv
// -----------------------------------------------------------------------------
// ppoe_ellipse
// Three-stage inside-ellipse test: dx^2*b^2 + dy^2*a^2 <= a^2*b^2.
// -----------------------------------------------------------------------------
module ppoe_ellipse #(
  parameter int COORD_BITS = ppoe_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  ppoe_pkg::stage_ld_t   ld,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] radius_x,
  input  logic [COORD_BITS-1:0] radius_y,
  output logic                  in_roi
);
  import ppoe_pkg::*;

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int PR_W = 4 * COORD_BITS;

  // stage 1: distances, squared radii
  logic [COORD_BITS-1:0] dx_s1, dy_s1;
  logic [SQ_W-1:0]       a2_s1, b2_s1;
  logic                  zero_s1;
  // stage 2: squared distances
  logic [SQ_W-1:0]       dx2_s2, dy2_s2, a2_s2, b2_s2;
  logic                  zero_s2;
  // stage 3: cross products
  logic [PR_W-1:0]       px_s3, py_s3, pr_s3;
  logic                  zero_s3;
  logic [PR_W:0]         lhs;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      dx_s1   <= (pos_x >= center_x) ? pos_x - center_x : center_x - pos_x;
      dy_s1   <= (pos_y >= center_y) ? pos_y - center_y : center_y - pos_y;
      a2_s1   <= SQ_W'(radius_x) * SQ_W'(radius_x);
      b2_s1   <= SQ_W'(radius_y) * SQ_W'(radius_y);
      zero_s1 <= (radius_x == '0) || (radius_y == '0);
    end
    if (ld.s2) begin
      dx2_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
      dy2_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
      a2_s2   <= a2_s1;
      b2_s2   <= b2_s1;
      zero_s2 <= zero_s1;
    end
    if (ld.s3) begin
      px_s3   <= PR_W'(dx2_s2) * PR_W'(b2_s2);
      py_s3   <= PR_W'(dy2_s2) * PR_W'(a2_s2);
      pr_s3   <= PR_W'(a2_s2) * PR_W'(b2_s2);
      zero_s3 <= zero_s2;
    end
  end

  assign lhs    = {1'b0, px_s3} + {1'b0, py_s3};
  assign in_roi = !zero_s3 && (lhs <= {1'b0, pr_s3});

endmodule

>>> rtl/core/pixel_point_op_ellipse_roi.sv
// -----------------------------------------------------------------------------
// pixel_point_op_ellipse_roi - threshold/brightness point op with ellipse ROI
// Pipeline: 4 register stages; an accepted input passes s1, s2, s3 and then the output register.
// Throughput: 1 pixel per cycle while the sink keeps up; the dx^2*b^2 multiply chain sets the depth.
// Reset: sync, active high; empties the pipe and restores register defaults.
// -----------------------------------------------------------------------------
`include "pixel_point_op_ellipse_roi_defines.svh"

module pixel_point_op_ellipse_roi #(
  parameter int COORD_BITS = ppoe_pkg::COORD_BITS_DEF,
  parameter int CFG_W      = (COORD_BITS > 9) ? COORD_BITS : 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ppoe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  ppoe_pix_in_if.sink                    pix_in,
  ppoe_pix_out_if.source                 pix_out
);
  import ppoe_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                  op_mode;
  logic [7:0]            threshold_level;
  logic signed [8:0]     brightness_offset;
  logic                  mask_enable;
  logic [COORD_BITS-1:0] center_x, center_y, radius_x, radius_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode           <= OP_THRESHOLD;
      threshold_level   <= THRESHOLD_RST;
      brightness_offset <= '0;
      mask_enable       <= 1'b0;
      center_x          <= '0;
      center_y          <= '0;
      radius_x          <= '0;
      radius_y          <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_OP_MODE:    op_mode           <= cfg_data[0];
        REG_THRESHOLD:  threshold_level   <= cfg_data[7:0];
        REG_BRIGHTNESS: brightness_offset <= $signed(cfg_data[8:0]);
        REG_MASK_EN:    mask_enable       <= cfg_data[0];
        REG_CENTER_X:   center_x          <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:   center_y          <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_X:   radius_x          <= cfg_data[COORD_BITS-1:0];
        REG_RADIUS_Y:   radius_y          <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // Each stage loads when it is empty or its contents move on this cycle, so
  // bubbles collapse and a full pipe still takes a transfer every cycle while
  // the sink keeps up. Ready ripples back from the output register.
  // ---------------------------------------------------------------------------
  logic      valid_s1, valid_s2, valid_s3, valid_s4;
  stage_ld_t ld;

  assign ld.s4 = !valid_s4 || pix_out.ready;
  assign ld.s3 = !valid_s3 || ld.s4;
  assign ld.s2 = !valid_s2 || ld.s3;
  assign ld.s1 = !valid_s1 || ld.s2;

  assign pix_in.ready = ld.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
      valid_s4 <= 1'b0;
    end else begin
      if (ld.s1) begin
        valid_s1 <= pix_in.valid;
      end
      if (ld.s2) begin
        valid_s2 <= valid_s1;
      end
      if (ld.s3) begin
        valid_s3 <= valid_s2;
      end
      if (ld.s4) begin
        valid_s4 <= valid_s3;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel path: the point op is cheap, so it is worked out on entry and both
  // the original and processed pixels ride alongside the geometry stages.
  // ---------------------------------------------------------------------------
  rgb_t pix_src, pix_proc;
  rgb_t orig_s1, orig_s2, orig_s3;
  rgb_t proc_s1, proc_s2, proc_s3;

  assign pix_src = '{red: pix_in.in_red, green: pix_in.in_green, blue: pix_in.in_blue};

  ppoe_pixel_op u_pixel_op (
    .op_mode           (op_mode),
    .threshold_level   (threshold_level),
    .brightness_offset (brightness_offset),
    .pix               (pix_src),
    .result            (pix_proc)
  );

  // Geometry: |d| and r^2, then d^2, then cross products; compare feeds stage 4.
  logic in_roi;

  ppoe_ellipse #(
    .COORD_BITS (COORD_BITS)
  ) u_ellipse (
    .clk      (clk),
    .ld       (ld),
    .pos_x    (pix_in.pos_x),
    .pos_y    (pix_in.pos_y),
    .center_x (center_x),
    .center_y (center_y),
    .radius_x (radius_x),
    .radius_y (radius_y),
    .in_roi   (in_roi)
  );

  logic active;
  assign active = !mask_enable || in_roi;

  always_ff @(posedge clk) begin
    if (ld.s1) begin
      orig_s1 <= pix_src;
      proc_s1 <= pix_proc;
    end
    if (ld.s2) begin
      orig_s2 <= orig_s1;
      proc_s2 <= proc_s1;
    end
    if (ld.s3) begin
      orig_s3 <= orig_s2;
      proc_s3 <= proc_s2;
    end
    // output register: pixels outside the region pass untouched
    if (ld.s4) begin
      pix_out.out_red     <= active ? proc_s3.red   : orig_s3.red;
      pix_out.out_green   <= active ? proc_s3.green : orig_s3.green;
      pix_out.out_blue    <= active ? proc_s3.blue  : orig_s3.blue;
      pix_out.was_changed <= active;
    end
  end

  assign pix_out.valid = valid_s4;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // input back-pressure only when every stage holds a pixel
  `PPOE_ASSERT_IMPLY(a_stall_full, clk, rst, !pix_in.ready, valid_s1 && valid_s2 && valid_s3 && valid_s4)
  // reset drains the pipe
  `PPOE_ASSERT_NEXT(a_rst_empty, clk, rst, !valid_s1 && !valid_s2 && !valid_s3 && !valid_s4)
  // a pixel in stage 3 that may advance reaches the output register
  `PPOE_ASSERT_IMPLY(a_s3_moves, clk, rst, valid_s3 && !valid_s4, ld.s4)

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb - pixel_point_op_ellipse_roi testbench
// A short table of directed pixels and register writes comes first: threshold
// edges, clamp limits, zero radius, ellipse boundary and register bits beyond
// each field's width. About a thousand random pixels follow, spread over
// several register settings. Input gaps and output back-pressure are random.
// Every output transfer is checked against a predicted pixel.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppoe_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int CFG_W     = (CB > 9) ? CB : 9;
  localparam int MAX_WAIT  = 12;
  localparam int N_PHASES  = 10;
  localparam int PHASE_PIX = 100;
  localparam int LIMIT     = 200000;   // cycles; watchdog limit

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    rgb_t          rgb;
  } pixel_t;

  typedef struct packed {
    rgb_t rgb;
    logic changed;
  } roi_pixel_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    cfg_reg_e   idx;
    logic [CFG_W-1:0] data;
    pixel_t     pix;
    bit         literal;   // expected pixel typed into the row
    roi_pixel_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ppoe_pix_in_if #(.COORD_BITS(CB)) pix_in_ch ();
  ppoe_pix_out_if                   pix_out_ch ();

  pixel_point_op_ellipse_roi #(.COORD_BITS(CB)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in_ch),
    .pix_out   (pix_out_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the register file, kept in step with every write
  // --------------------------------------------------------------------------
  op_mode_e          sh_op;
  logic [7:0]        sh_thr;
  logic signed [8:0] sh_offset;
  logic              sh_mask;
  logic [CB-1:0]     sh_cx, sh_cy, sh_rx, sh_ry;

  roi_pixel_t processed_q[$];   // predicted pixels, oldest first
  stim_row_t  stim_table[$];
  int         mismatches;
  int         cycles;
  bit         src_steady;       // no input gaps while set
  bit         sink_steady;      // no back-pressure while set
  int         sink_hold;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // exact integer form: dx^2*b^2 + dy^2*a^2 <= a^2*b^2, zero radius is empty
  function automatic bit in_ellipse(logic [CB-1:0] px, logic [CB-1:0] py);
    longint unsigned dx, dy, a2, b2;
    if (sh_rx == '0 || sh_ry == '0) return 1'b0;
    dx = (px >= sh_cx) ? longint'(px) - longint'(sh_cx) : longint'(sh_cx) - longint'(px);
    dy = (py >= sh_cy) ? longint'(py) - longint'(sh_cy) : longint'(sh_cy) - longint'(py);
    a2 = longint'(sh_rx) * longint'(sh_rx);
    b2 = longint'(sh_ry) * longint'(sh_ry);
    return (dx * dx * b2 + dy * dy * a2) <= (a2 * b2);
  endfunction

  function automatic logic [7:0] add_sat(logic [7:0] chan);
    int s;
    s = int'(chan) + int'(sh_offset);
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  function automatic roi_pixel_t point_op(pixel_t p);
    roi_pixel_t o;
    o.rgb     = p.rgb;
    o.changed = !sh_mask || in_ellipse(p.x, p.y);
    if (o.changed) begin
      if (sh_op == OP_THRESHOLD) begin
        // packed R:G:B word against t:t:t
        o.rgb = (p.rgb < {sh_thr, sh_thr, sh_thr}) ? 24'h000000 : 24'hFFFFFF;
      end else begin
        o.rgb.red   = add_sat(p.rgb.red);
        o.rgb.green = add_sat(p.rgb.green);
        o.rgb.blue  = add_sat(p.rgb.blue);
      end
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Register writes: only with nothing in flight. Upper data bits beyond the
  // field width are dropped, as in the block.
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    while (processed_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_OP_MODE:    sh_op     = op_mode_e'(data[0]);
      REG_THRESHOLD:  sh_thr    = data[7:0];
      REG_BRIGHTNESS: sh_offset = data[8:0];
      REG_MASK_EN:    sh_mask   = data[0];
      REG_CENTER_X:   sh_cx     = data[CB-1:0];
      REG_CENTER_Y:   sh_cy     = data[CB-1:0];
      REG_RADIUS_X:   sh_rx     = data[CB-1:0];
      REG_RADIUS_Y:   sh_ry     = data[CB-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic int draw_wait(bit steady);
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // One pixel transfer. valid is held high across back-to-back transfers;
  // it is lowered only when a gap is drawn.
  task automatic send_pixel(pixel_t p, bit literal, roi_pixel_t want);
    int gap;
    gap = draw_wait(src_steady);
    if (gap != 0) begin
      pix_in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_ch.valid    <= 1'b1;
    pix_in_ch.pos_x    <= p.x;
    pix_in_ch.pos_y    <= p.y;
    pix_in_ch.in_red   <= p.rgb.red;
    pix_in_ch.in_green <= p.rgb.green;
    pix_in_ch.in_blue  <= p.rgb.blue;
    do @(posedge clk); while (!(pix_in_ch.valid && pix_in_ch.ready));
    processed_q.push_back(literal ? want : point_op(p));
  endtask

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void row_write(cfg_reg_e idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    r.pix  = '0;
    r.literal = 1'b0;
    r.want = '0;
    stim_table.push_back(r);
  endfunction

  function automatic void row_pix(int x, int y, logic [23:0] rgb,
                                  bit literal = 1'b0, logic [24:0] want = '0);
    stim_row_t r;
    r.kind    = ROW_PIXEL;
    r.idx     = REG_OP_MODE;
    r.data    = '0;
    r.pix     = {x[CB-1:0], y[CB-1:0], rgb};
    r.literal = literal;
    r.want    = want;
    stim_table.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Random register settings. kind 0 takes the low extremes, kind 1 the high
  // extremes, anything else draws at random with the extremes weighted in.
  // --------------------------------------------------------------------------
  function automatic logic [CFG_W-1:0] pick(int lo, int hi, int kind);
    case (kind)
      0: return lo[CFG_W-1:0];
      1: return hi[CFG_W-1:0];
      default: begin
        case ($urandom_range(0, 7))
          0: return lo[CFG_W-1:0];
          1: return hi[CFG_W-1:0];
          default: return CFG_W'($urandom_range(lo, hi));
        endcase
      end
    endcase
  endfunction

  task automatic random_setup(int kind);
    logic [CFG_W-1:0] off;
    logic [CFG_W-1:0] rad;
    // stray bits above the field width ride along on the 1-bit op_mode register
    write_reg(REG_OP_MODE,   (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'($urandom_range(0, 1)));
    write_reg(REG_THRESHOLD, pick(0, 255, kind));
    case (kind)
      0: off = CFG_W'(9'h100);        // -256
      1: off = CFG_W'(9'h0FF);        // +255
      default: off = CFG_W'($urandom);
    endcase
    write_reg(REG_BRIGHTNESS, off);
    write_reg(REG_MASK_EN, ($urandom_range(0, 2) != 0) ? CFG_W'(1) : CFG_W'(0));
    write_reg(REG_CENTER_X, pick(0, 1023, kind));
    write_reg(REG_CENTER_Y, pick(0, 1023, kind));
    // mostly moderate radii so the boundary is hit often
    rad = (kind < 2) ? pick(0, 1023, kind) : pick(0, 1023, ($urandom_range(0, 3) == 0) ? 2 : 3);
    if (kind >= 2 && $urandom_range(0, 3) != 0) rad = CFG_W'($urandom_range(1, 300));
    write_reg(REG_RADIUS_X, rad);
    rad = (kind < 2) ? pick(0, 1023, kind) : CFG_W'($urandom_range(1, 300));
    if (kind >= 2 && $urandom_range(0, 7) == 0) rad = pick(0, 1023, 2);
    write_reg(REG_RADIUS_Y, rad);
  endtask

  // coordinate near the ellipse so both sides of the boundary get traffic
  function automatic logic [CB-1:0] near_axis(logic [CB-1:0] c, logic [CB-1:0] r);
    int span, v;
    span = int'(r) + int'(r) / 4 + 2;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[CB-1:0];
  endfunction

  function automatic logic [7:0] rand_chan();
    int v;
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: begin
        v = int'(sh_thr) + int'($urandom_range(0, 2)) - 1;   // around t
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    if (sh_mask && $urandom_range(0, 3) != 0) begin
      p.x = near_axis(sh_cx, sh_rx);
      p.y = near_axis(sh_cy, sh_ry);
    end else begin
      p.x = CB'($urandom);
      p.y = CB'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      // word right at t:t:t, then nudge the blue byte
      p.rgb = {sh_thr, sh_thr, sh_thr};
      p.rgb.blue = p.rgb.blue + 8'($urandom_range(0, 2)) - 8'd1;
    end else begin
      p.rgb.red   = rand_chan();
      p.rgb.green = rand_chan();
      p.rgb.blue  = rand_chan();
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the check of each transfer
  // --------------------------------------------------------------------------
  task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel();
    roi_pixel_t want;
    if (processed_q.size() == 0) begin
      $display("%0t: pixel out with none expected, got %h %h %h %b", $time,
               pix_out_ch.out_red, pix_out_ch.out_green, pix_out_ch.out_blue,
               pix_out_ch.was_changed);
      mismatches++;
    end else begin
      want = processed_q.pop_front();
      report_field("out_red",     want.rgb.red,   pix_out_ch.out_red);
      report_field("out_green",   want.rgb.green, pix_out_ch.out_green);
      report_field("out_blue",    want.rgb.blue,  pix_out_ch.out_blue);
      report_field("was_changed", 8'(want.changed), 8'(pix_out_ch.was_changed));
    end
  endtask

  // after a transfer ready may drop; sink_hold counts down a drawn wait before it rises again
  always @(posedge clk) begin
    if (rst) begin
      pix_out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (pix_out_ch.valid && pix_out_ch.ready) begin
      check_pixel();
      sink_hold = draw_wait(sink_steady);
      if (sink_hold != 0) pix_out_ch.ready <= 1'b0;
    end else if (!pix_out_ch.ready) begin
      if (sink_hold > 1) sink_hold--;
      else pix_out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t  row;
    pixel_t     p;
    roi_pixel_t none;

    none        = '0;
    mismatches  = 0;
    cycles      = 0;
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pix_in_ch.valid    = 1'b0;
    pix_in_ch.pos_x    = '0;
    pix_in_ch.pos_y    = '0;
    pix_in_ch.in_red   = '0;
    pix_in_ch.in_green = '0;
    pix_in_ch.in_blue  = '0;
    pix_out_ch.ready   = 1'b0;

    // register defaults after reset
    sh_op     = OP_THRESHOLD;
    sh_thr    = THRESHOLD_RST;
    sh_offset = '0;
    sh_mask   = 1'b0;
    sh_cx     = '0;
    sh_cy     = '0;
    sh_rx     = '0;
    sh_ry     = '0;

    // reset defaults: threshold 127, no mask
    row_pix(0, 0, 24'h000000, 1, {24'h000000, 1'b1});
    row_pix(1023, 1023, 24'hFFFFFF, 1, {24'hFFFFFF, 1'b1});
    row_pix(5, 7, 24'h7F7F7F, 1, {24'hFFFFFF, 1'b1});     // equal word is not below
    row_pix(5, 7, 24'h7F7F7E, 1, {24'h000000, 1'b1});
    row_pix(512, 300, 24'h7F8000, 1, {24'hFFFFFF, 1'b1}); // green lifts the word
    row_write(REG_THRESHOLD, 10'd0);
    row_pix(3, 3, 24'h000000, 1, {24'hFFFFFF, 1'b1});
    row_write(REG_THRESHOLD, 10'd255);
    row_pix(9, 9, 24'hFFFFFE, 1, {24'h000000, 1'b1});
    row_pix(9, 9, 24'hFFFFFF, 1, {24'hFFFFFF, 1'b1});
    // brightness; bits above bit 0 of op_mode must be dropped
    row_write(REG_OP_MODE, 10'h3FF);
    row_write(REG_BRIGHTNESS, 10'h0FF);
    row_pix(1, 2, 24'h000180, 1, {24'hFFFFFF, 1'b1});     // clamp high
    row_write(REG_BRIGHTNESS, 10'h100);
    row_pix(1, 2, 24'hFF8000, 1, {24'h000000, 1'b1});     // -256, clamp low
    row_write(REG_BRIGHTNESS, 10'h381);                   // -127 with bit 9 set
    row_pix(1, 2, 24'hC87F0A, 1, {24'h490000, 1'b1});
    row_write(REG_BRIGHTNESS, 10'h010);
    row_pix(100, 100, 24'h0A141E);
    // mask with both radii zero: nothing inside
    row_write(REG_MASK_EN, 10'd1);
    row_pix(0, 0, 24'h0A141E, 1, {24'h0A141E, 1'b0});
    row_write(REG_CENTER_X, 10'd512);
    row_write(REG_CENTER_Y, 10'd512);
    row_write(REG_RADIUS_X, 10'd100);
    row_pix(512, 512, 24'h0A141E, 1, {24'h0A141E, 1'b0}); // one radius still zero
    row_write(REG_RADIUS_Y, 10'd50);
    row_pix(512, 512, 24'h0A141E);
    row_pix(612, 512, 24'h0A141E);                        // on the boundary
    row_pix(613, 512, 24'h0A141E, 1, {24'h0A141E, 1'b0});
    row_pix(412, 512, 24'h0A141E);                        // left of centre
    row_pix(512, 562, 24'h0A141E);
    row_pix(512, 563, 24'h0A141E, 1, {24'h0A141E, 1'b0});
    row_pix(582, 547, 24'hF0F0F0);
    // back to threshold through a wide write; largest ellipse in the corner
    row_write(REG_OP_MODE, 10'h002);
    row_write(REG_RADIUS_X, 10'd1023);
    row_write(REG_RADIUS_Y, 10'd1023);
    row_write(REG_CENTER_X, 10'd0);
    row_write(REG_CENTER_Y, 10'd0);
    row_pix(1023, 0, 24'h808080);
    row_pix(723, 723, 24'h101010);
    row_pix(1023, 1023, 24'h123456, 1, {24'h123456, 1'b0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_WRITE) begin
        pix_in_ch.valid <= 1'b0;
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.pix, row.literal, row.want);
      end
    end
    pix_in_ch.valid <= 1'b0;

    // random phases: first the low extremes, then the high, then drawn
    for (int ph = 0; ph < N_PHASES; ph++) begin
      random_setup((ph < 2) ? ph : 2);
      src_steady  = (ph % 3 == 1);
      sink_steady = (ph % 4 == 2);
      for (int n = 0; n < PHASE_PIX; n++) begin
        p = rand_pixel();
        send_pixel(p, 1'b0, none);
      end
      pix_in_ch.valid <= 1'b0;
    end

    // drain; keep the output open long enough to catch a stray transfer
    sink_steady = 1'b1;
    while (processed_q.size() != 0) @(posedge clk);
    repeat (MAX_WAIT + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
